>>> rtl/ffrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffrm_pkg;

	// Map geometry
	localparam int MAP_ENTRIES = 32;
	localparam int ADDR_BITS   = 16;
	localparam int IDX_W       = (MAP_ENTRIES > 2) ? $clog2(MAP_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

	// Request actions
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Response status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// One free extent
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] len;
	} ffrm_ext_t;

	// Result of the shared adder
	typedef struct packed {
		logic                 carry;
		logic [ADDR_BITS-1:0] value;
		logic [ADDR_BITS-1:0] sat;
	} ffrm_sum_t;

endpackage

`default_nettype wire

>>> rtl/ffrm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: allocate or free
interface ffrm_req_if;
	import ffrm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [ADDR_BITS-1:0] unit_count;
	logic [ADDR_BITS-1:0] base_address;

	modport source (output valid, action, unit_count, base_address, input ready);
	modport sink   (input valid, action, unit_count, base_address, output ready);
endinterface

// Response channel: one per request
interface ffrm_rsp_if;
	import ffrm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] granted_base;
	logic [1:0]           status;

	modport source (output valid, granted_base, status, input ready);
	modport sink   (input valid, granted_base, status, output ready);
endinterface

`default_nettype wire

>>> rtl/ffrm_addsub.sv
`timescale 1ns / 1ps
`default_nettype none

module ffrm_addsub (
	input  logic [ffrm_pkg::ADDR_BITS-1:0] a,
	input  logic [ffrm_pkg::ADDR_BITS-1:0] b,
	input  logic                           sub,
	output ffrm_pkg::ffrm_sum_t            res
);
	import ffrm_pkg::*;

	logic [ADDR_BITS:0] sum;

	// Add, or subtract by inverted operand plus one; carry set means a >= b on subtract
	assign sum = {1'b0, a} + {1'b0, b ^ {ADDR_BITS{sub}}} + {{ADDR_BITS{1'b0}}, sub};

	// Saturate an add that overflows the address width
	always_comb begin
		res.carry = sum[ADDR_BITS];
		res.value = sum[ADDR_BITS-1:0];
		res.sat   = sum[ADDR_BITS] ? {ADDR_BITS{1'b1}} : sum[ADDR_BITS-1:0];
	end

endmodule

`default_nettype wire

>>> rtl/first_fit_resource_map_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                   Transfer
// req      in   action, unit_count, base_address          valid & ready
// rsp      out  granted_base, status                      valid & ready
//
// One request at a time; each entry scanned is first read, then used.
// Allocate takes from the first extent that fits; one used up is closed by moving
// the later entries down, and a miss scans the whole list. Free answers zero units
// without a scan, else finds the extents at or below the base, joins the neighbours
// it touches, or else inserts. Reset empties the list at once, with no clearing pass.
// A waiting response does not stop a new request; it only holds the next result.

module first_fit_resource_map_top (
	input  logic       clk,
	input  logic       arst_n,
	ffrm_req_if.sink   req,
	ffrm_rsp_if.source rsp
);
	import ffrm_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN_RD  = 4'd1;
	localparam logic [3:0] S_SCAN_CHK = 4'd2;
	localparam logic [3:0] S_A_BASE   = 4'd3;
	localparam logic [3:0] S_F_PREV   = 4'd4;
	localparam logic [3:0] S_F_END    = 4'd5;
	localparam logic [3:0] S_F_JP1    = 4'd6;
	localparam logic [3:0] S_F_JP2    = 4'd7;
	localparam logic [3:0] S_F_JN     = 4'd8;
	localparam logic [3:0] S_SH_RD    = 4'd9;
	localparam logic [3:0] S_SH_WR    = 4'd10;
	localparam logic [3:0] S_RESP     = 4'd11;

	logic [3:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     p_q;
	logic [CNT_W-1:0]     k_q;
	logic                 shift_up_q;
	logic                 prev_v_q;
	logic                 next_v_q;
	logic                 join_prev_q;
	logic                 touch_next_q;
	logic                 action_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] len_q;
	ffrm_ext_t            prev_q;
	ffrm_ext_t            next_q;
	logic [ADDR_BITS-1:0] pend_base_q;
	logic [1:0]           pend_status_q;
	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] out_base_q;
	logic [1:0]           out_status_q;

	ffrm_ext_t            mem_q [MAP_ENTRIES];
	ffrm_ext_t            rd_data_q;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	ffrm_ext_t            wr_data;

	logic [ADDR_BITS-1:0] alu_a;
	logic [ADDR_BITS-1:0] alu_b;
	logic                 alu_sub;
	ffrm_sum_t            alu_res;

	logic [CNT_W-1:0]     k_inc;
	logic [CNT_W-1:0]     k_dec;
	logic [CNT_W-1:0]     p_dec;
	logic                 shift_done;
	logic                 touch_next;
	logic                 rsp_load;

	assign k_inc = k_q + CNT_W'(1);
	assign k_dec = k_q - CNT_W'(1);
	assign p_dec = p_q - CNT_W'(1);
	assign shift_done = shift_up_q ? !(k_q > p_q) : !(k_inc < count_q);
	assign touch_next = next_v_q && ({alu_res.carry, alu_res.value} == {1'b0, next_q.base});
	assign rsp_load = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.granted_base = out_base_q;
	assign rsp.status       = out_status_q;

	// Shared adder
	ffrm_addsub u_addsub (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	// Select adder operands per step
	always_comb begin
		alu_a   = size_q;
		alu_b   = size_q;
		alu_sub = 1'b0;
		unique case (state_q)
			S_SCAN_CHK: begin
				alu_a   = rd_data_q.len;
				alu_sub = 1'b1;
			end
			S_A_BASE: alu_a = pend_base_q;
			S_F_PREV: begin
				alu_a = prev_q.base;
				alu_b = prev_q.len;
			end
			S_F_END:  alu_a = addr_q;
			S_F_JP1:  alu_a = prev_q.len;
			S_F_JP2: begin
				alu_a = len_q;
				alu_b = next_q.len;
			end
			S_F_JN:   alu_a = next_q.len;
			default: begin
				alu_a = size_q;
			end
		endcase
	end

	// Drive memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = p_q[IDX_W-1:0];
		wr_data = '{base: addr_q, len: size_q};
		unique case (state_q)
			S_SCAN_RD: rd_en = (idx_q != count_q);
			S_A_BASE: begin
				wr_en   = (len_q != '0);
				wr_data = '{base: alu_res.value, len: len_q};
			end
			S_F_JP1: begin
				wr_en   = !touch_next_q;
				wr_addr = p_dec[IDX_W-1:0];
				wr_data = '{base: prev_q.base, len: alu_res.sat};
			end
			S_F_JP2: begin
				wr_en   = 1'b1;
				wr_addr = p_dec[IDX_W-1:0];
				wr_data = '{base: prev_q.base, len: alu_res.sat};
			end
			S_F_JN: begin
				wr_en   = 1'b1;
				wr_data = '{base: addr_q, len: alu_res.sat};
			end
			S_SH_RD: begin
				rd_en   = !shift_done;
				rd_addr = shift_up_q ? k_dec[IDX_W-1:0] : k_inc[IDX_W-1:0];
				wr_en   = shift_done && shift_up_q;
			end
			S_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = k_q[IDX_W-1:0];
				wr_data = rd_data_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Extent memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken response unless a new one replaces it
			if (rsp.ready && !rsp_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						action_q      <= req.action;
						size_q        <= req.unit_count;
						addr_q        <= req.base_address;
						idx_q         <= '0;
						prev_v_q      <= 1'b0;
						next_v_q      <= 1'b0;
						pend_base_q   <= '0;
						pend_status_q <= ST_DONE;
						if (req.action == ACT_FREE && req.unit_count == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						p_q <= idx_q;
						if (action_q == ACT_ALLOC) begin
							pend_status_q <= ST_NO_FIT;
							state_q       <= S_RESP;
						end else begin
							state_q <= S_F_PREV;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (action_q == ACT_ALLOC) begin
						// first fit: length covers the request
						if (alu_res.carry) begin
							pend_base_q <= rd_data_q.base;
							len_q       <= alu_res.value;
							p_q         <= idx_q;
							state_q     <= S_A_BASE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_SCAN_RD;
						end
					end else begin
						// find first extent above the freed base
						if (rd_data_q.base <= addr_q) begin
							prev_q   <= rd_data_q;
							prev_v_q <= 1'b1;
							idx_q    <= idx_q + CNT_W'(1);
							state_q  <= S_SCAN_RD;
						end else begin
							next_q   <= rd_data_q;
							next_v_q <= 1'b1;
							p_q      <= idx_q;
							state_q  <= S_F_PREV;
						end
					end
				end
				S_A_BASE: begin
					if (len_q == '0) begin
						k_q        <= p_q;
						shift_up_q <= 1'b0;
						state_q    <= S_SH_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_F_PREV: begin
					join_prev_q <= prev_v_q &&
						({alu_res.carry, alu_res.value} == {1'b0, addr_q});
					state_q <= S_F_END;
				end
				S_F_END: begin
					touch_next_q <= touch_next;
					if (join_prev_q) begin
						state_q <= S_F_JP1;
					end else if (touch_next) begin
						state_q <= S_F_JN;
					end else if (count_q == CNT_W'(MAP_ENTRIES)) begin
						pend_status_q <= ST_FULL;
						state_q       <= S_RESP;
					end else begin
						k_q        <= count_q;
						shift_up_q <= 1'b1;
						state_q    <= S_SH_RD;
					end
				end
				S_F_JP1: begin
					len_q   <= alu_res.sat;
					state_q <= touch_next_q ? S_F_JP2 : S_RESP;
				end
				S_F_JP2: begin
					k_q        <= p_q;
					shift_up_q <= 1'b0;
					state_q    <= S_SH_RD;
				end
				S_F_JN: begin
					state_q <= S_RESP;
				end
				S_SH_RD: begin
					if (shift_done) begin
						count_q <= shift_up_q ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					k_q     <= shift_up_q ? k_dec : k_inc;
					state_q <= S_SH_RD;
				end
				S_RESP: begin
					// hold until the output register is free
					if (rsp_load) begin
						out_valid_q  <= 1'b1;
						out_base_q   <= pend_base_q;
						out_status_q <= pend_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// List never grows past its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAP_ENTRIES))
		else $error("extent count above capacity");

	// Count moves by one entry at most per request
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CNT_W'(1)) ||
			(count_q == $past(count_q) - CNT_W'(1)))
		else $error("extent count jumped");

	// List full is only reported on a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && pend_status_q == ST_FULL) |-> count_q == CNT_W'(MAP_ENTRIES))
		else $error("list full reported on a list with room");

	// Writes stay within the used list plus one
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CNT_W'(wr_addr) <= count_q)
		else $error("extent write beyond list end");
`endif

endmodule

`default_nettype wire

>>> dv/tb_first_fit_resource_map_top.sv
`timescale 1ns / 1ps

module tb_first_fit_resource_map_top;
	import ffrm_pkg::*;

	typedef enum int {QUIET, SRC_IDLE, SNK_STALL, BOTH_IDLE} idle_mode_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] granted_base;
		logic [1:0]           status;
	} grant_t;

	typedef struct packed {
		logic                 action;
		logic [ADDR_BITS-1:0] unit_count;
		logic [ADDR_BITS-1:0] base_address;
		logic                 typed;
		grant_t               typed_grant;
	} stim_row_t;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_MAX   = 10;
	localparam int PHASE_ITEMS  = 262;
	localparam int BURST_ITEMS  = 40;
	localparam int DIRECTED_N   = 25;

	// Directed requests; a typed grant is checked as written, the rest by the map predictor
	localparam stim_row_t DIRECTED [DIRECTED_N] = '{
		'{ACT_ALLOC, 16'h0000, 16'h0000, 1'b1, '{16'h0000, ST_NO_FIT}},
		'{ACT_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, ST_NO_FIT}},
		'{ACT_FREE,  16'h0000, 16'h1234, 1'b1, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0100, 16'h1000, 1'b1, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'h0000, 16'h0000, 1'b1, '{16'h1000, ST_DONE}},
		'{ACT_ALLOC, 16'h0010, 16'h5A5A, 1'b1, '{16'h1000, ST_DONE}},
		'{ACT_FREE,  16'h0010, 16'h1000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0020, 16'h1100, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0010, 16'h2000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0EE0, 16'h1120, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0010, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'h1010, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'h0011, 16'h0000, 1'b1, '{16'h0000, ST_NO_FIT}},
		'{ACT_ALLOC, 16'h0010, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'hFFFF, 16'hFFFF, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'h0005, 16'h0000, 1'b1, '{16'hFFFF, ST_DONE}},
		'{ACT_ALLOC, 16'hFFFA, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h8000, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h9000, 16'h8000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0010, 16'hFFFF, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h0001, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'hFFFF, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_ALLOC, 16'h0001, 16'h0000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'h7FFF, 16'h8000, 1'b0, '{16'h0000, ST_DONE}},
		'{ACT_FREE,  16'hFFFF, 16'h0001, 1'b0, '{16'h0000, ST_DONE}}
	};

	logic clk;
	logic arst_n;

	ffrm_req_if req_ch ();
	ffrm_rsp_if rsp_ch ();

	first_fit_resource_map_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted free list
	logic [ADDR_BITS-1:0] free_base [MAP_ENTRIES];
	logic [ADDR_BITS-1:0] free_len  [MAP_ENTRIES];
	int                   free_cnt;

	// Extents granted so far and not yet returned
	logic [ADDR_BITS-1:0] owned_base [$];
	logic [ADDR_BITS-1:0] owned_size [$];

	grant_t     awaited_grants [$];
	int         mismatches = 0;
	int         cycle_count = 0;
	idle_mode_t idle_mode;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** first_fit_resource_map_top: FAILED **");
			$finish;
		end
	end

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int idle_pct(input bit sink_side);
		case (idle_mode)
			SRC_IDLE:  return sink_side ? 0 : 69;
			SNK_STALL: return sink_side ? 69 : 0;
			BOTH_IDLE: return 27;
			default:   return 0;
		endcase
	endfunction

	function automatic logic [ADDR_BITS-1:0] clip_len(input logic [ADDR_BITS:0] v);
		return (v > {1'b0, {ADDR_BITS{1'b1}}}) ? {ADDR_BITS{1'b1}} : v[ADDR_BITS-1:0];
	endfunction

	// Close the gap left by extent idx
	function automatic void drop_extent(input int idx);
		int k;
		for (k = idx; k + 1 < free_cnt; k++) begin
			free_base[k] = free_base[k + 1];
			free_len[k]  = free_len[k + 1];
		end
		free_cnt--;
	endfunction

	// Apply one request to the predicted list and return the grant it yields
	function automatic void map_request(input logic act, input logic [ADDR_BITS-1:0] cnt,
			input logic [ADDR_BITS-1:0] addr, output grant_t res);
		int                 i;
		int                 p;
		int                 k;
		bit                 hit;
		logic [ADDR_BITS:0] fin;
		res.granted_base = '0;
		res.status       = ST_DONE;
		hit              = 1'b0;
		if (act == ACT_ALLOC) begin
			// first fit: carve from the front, drop the extent when used up
			for (i = 0; i < free_cnt && !hit; i++) begin
				if (free_len[i] >= cnt) begin
					hit              = 1'b1;
					res.granted_base = free_base[i];
					free_base[i]     = free_base[i] + cnt;
					free_len[i]      = free_len[i] - cnt;
					if (free_len[i] == '0)
						drop_extent(i);
				end
			end
			if (!hit)
				res.status = ST_NO_FIT;
		end else if (cnt != '0) begin
			fin = {1'b0, addr} + cnt;
			p   = 0;
			while (p < free_cnt && free_base[p] <= addr)
				p++;
			if (p > 0 && {1'b0, free_base[p-1]} + free_len[p-1] == {1'b0, addr}) begin
				// join the predecessor, then maybe the successor too
				free_len[p-1] = clip_len({1'b0, free_len[p-1]} + cnt);
				if (p < free_cnt && fin == {1'b0, free_base[p]}) begin
					free_len[p-1] = clip_len({1'b0, free_len[p-1]} + free_len[p]);
					drop_extent(p);
				end
			end else if (p < free_cnt && fin == {1'b0, free_base[p]}) begin
				free_base[p] = addr;
				free_len[p]  = clip_len({1'b0, free_len[p]} + cnt);
			end else if (free_cnt >= MAP_ENTRIES) begin
				res.status = ST_FULL;
			end else begin
				for (k = free_cnt; k > p; k--) begin
					free_base[k] = free_base[k-1];
					free_len[k]  = free_len[k-1];
				end
				free_base[p] = addr;
				free_len[p]  = cnt;
				free_cnt++;
			end
		end
	endfunction

	// Drive one request, wait for its acceptance and log the grant it should get
	task automatic push_request(input logic act, input logic [ADDR_BITS-1:0] cnt,
			input logic [ADDR_BITS-1:0] addr, input logic typed, input grant_t typed_grant);
		grant_t res;
		while (roll(idle_pct(1'b0))) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.unit_count   <= cnt;
		req_ch.base_address <= addr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		map_request(act, cnt, addr, res);
		if (act == ACT_ALLOC && res.status == ST_DONE && cnt != '0) begin
			owned_base.push_back(res.granted_base);
			owned_size.push_back(cnt);
		end
		awaited_grants.push_back(typed ? typed_grant : res);
		@(negedge clk);
	endtask

	// Scattered small free, unlikely to touch anything
	task automatic scatter_free();
		logic [ADDR_BITS-1:0] a;
		a = ADDR_BITS'($urandom_range(0, 2047) * 32 + $urandom_range(0, 15));
		push_request(ACT_FREE, ADDR_BITS'($urandom_range(1, 8)), a, 1'b0, '0);
	endtask

	// Mostly allocate and give back, with some fragments and noise
	task automatic random_request();
		int                   r;
		int                   j;
		logic [ADDR_BITS-1:0] c;
		logic [ADDR_BITS-1:0] a;
		logic [ADDR_BITS-1:0] part;
		r = int'($urandom_range(0, 99));
		if (r < 35) begin
			case ($urandom_range(0, 9))
				0:       c = ADDR_BITS'($urandom);
				1:       c = '0;
				default: c = ADDR_BITS'($urandom_range(1, 96));
			endcase
			push_request(ACT_ALLOC, c, ADDR_BITS'($urandom), 1'b0, '0);
		end else if (r < 70 && owned_size.size() > 0) begin
			j = int'($urandom_range(0, owned_size.size() - 1));
			c = owned_size[j];
			a = owned_base[j];
			owned_base.delete(j);
			owned_size.delete(j);
			if (c > 1 && $urandom_range(0, 3) == 0) begin
				// return the tail, keep the head
				part = ADDR_BITS'($urandom_range(1, c - 1));
				owned_base.push_back(a);
				owned_size.push_back(part);
				push_request(ACT_FREE, c - part, a + part, 1'b0, '0);
			end else begin
				push_request(ACT_FREE, c, a, 1'b0, '0);
			end
		end else if (r < 82) begin
			scatter_free();
		end else if (r < 94) begin
			push_request(ACT_FREE, ADDR_BITS'($urandom), ADDR_BITS'($urandom), 1'b0, '0);
		end else begin
			push_request(1'($urandom_range(0, 1)), '0, ADDR_BITS'($urandom), 1'b0, '0);
		end
	endtask

	// Receiver: stall at random by phase
	always @(negedge clk) begin
		rsp_ch.ready <= !roll(idle_pct(1'b1));
	end

	// Compare each response with the oldest awaited grant
	always @(posedge clk) begin : check_grant
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response with no request outstanding: base %h status %0d",
						$realtime, rsp_ch.granted_base, rsp_ch.status);
			end else begin
				want = awaited_grants.pop_front();
				if (rsp_ch.granted_base !== want.granted_base || rsp_ch.status !== want.status) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: grant mismatch: want base %h status %0d, got base %h status %0d",
							$realtime, want.granted_base, want.status,
							rsp_ch.granted_base, rsp_ch.status);
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int i;
		int ph;
		req_ch.valid        = 1'b0;
		req_ch.action       = ACT_ALLOC;
		req_ch.unit_count   = '0;
		req_ch.base_address = '0;
		arst_n              = 1'b0;
		free_cnt            = 0;
		idle_mode           = QUIET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIRECTED_N; i++)
			push_request(DIRECTED[i].action, DIRECTED[i].unit_count, DIRECTED[i].base_address,
				DIRECTED[i].typed, DIRECTED[i].typed_grant);

		// Each phase opens by filling the list past capacity, then mixes requests
		for (ph = 0; ph < 4; ph++) begin
			idle_mode = idle_mode_t'(ph);
			repeat (BURST_ITEMS) scatter_free();
			repeat (PHASE_ITEMS - BURST_ITEMS) random_request();
		end
		req_ch.valid <= 1'b0;

		while (awaited_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** first_fit_resource_map_top: PASSED **");
		else
			$display("** first_fit_resource_map_top: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ffrm_pkg.sv
rtl/ffrm_if.sv
rtl/ffrm_addsub.sv
rtl/first_fit_resource_map_top.sv
dv/tb_first_fit_resource_map_top.sv
